### rtl/elr_pkg.sv
// Shared constants and types for the ellipse rasterizer.
`default_nettype none
package elr_pkg;

  localparam int MAX_DIM_DEFAULT = 256;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_BOX_W    = 3'd2;
  localparam logic [2:0] CFG_BOX_H    = 3'd3;
  localparam logic [2:0] CFG_COLOUR   = 3'd4;
  localparam logic [2:0] CFG_FILL     = 3'd5;
  localparam logic [2:0] CFG_CANVAS_W = 3'd6;
  localparam logic [2:0] CFG_CANVAS_H = 3'd7;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_COL  = 2'd1;
  localparam logic [1:0] PH_ROW  = 2'd2;

  // one walk position handed from the sequencer to the point stage
  typedef struct packed {
    logic       col;       // 1: column pass, 0: row pass
    logic [8:0] outer;     // outer index
    logic [1:0] step;      // point step
    logic [8:0] span;      // span index
    logic [7:0] r;         // extent
    logic       done;      // last point of the walk
    logic       empty;     // empty or idle word, no point
  } elr_cmd_t;

endpackage
`default_nettype wire

### rtl/ellipse_rasterizer_unit.sv
// Top level of the ellipse rasterizer: registers, front walker, back pixel stage.
// channel | signals                          | direction
// input   | in_valid/in_ready, restart       | in
// output  | out_valid/out_ready, 5 fields    | out
// config  | cfg_valid/cfg_ready, cfg_index   | in
// Each word may need one extent search when the walk moves to a new column or row
// or the box changes; the extent unit makes one test per cycle.
// Reset clears the walk and loads the register reset values.
// A two-entry queue parts the walker from the output register.
`default_nettype none
module ellipse_rasterizer_unit #(
  parameter int MAX_DIM = elr_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       restart,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            write_ok,
  output logic [7:0]      pixel_x,
  output logic [7:0]      pixel_y,
  output logic [7:0]      attribute,
  output logic            walk_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  logic [8:0] org_x, org_y, canvas_w, canvas_h;
  logic [7:0] box_w, box_h;
  logic [3:0] colour;
  logic       fill;
  logic       q_valid, q_ready;
  elr_pkg::elr_cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0; org_y <= '0; box_w <= '0; box_h <= '0;
      colour <= '0; fill <= 1'b0; canvas_w <= 9'd256; canvas_h <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        elr_pkg::CFG_ORIGIN_X: org_x <= cfg_data;
        elr_pkg::CFG_ORIGIN_Y: org_y <= cfg_data;
        elr_pkg::CFG_BOX_W:    box_w <= cfg_data[7:0];
        elr_pkg::CFG_BOX_H:    box_h <= cfg_data[7:0];
        elr_pkg::CFG_COLOUR:   colour <= cfg_data[3:0];
        elr_pkg::CFG_FILL:     fill <= cfg_data[0];
        elr_pkg::CFG_CANVAS_W: canvas_w <= cfg_data;
        elr_pkg::CFG_CANVAS_H: canvas_h <= cfg_data;
        default: ;
      endcase
    end
  end

  elr_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .restart(restart), .box_w(box_w), .box_h(box_h), .fill(fill),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  elr_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .org_x(org_x), .org_y(org_y), .box_w(box_w), .box_h(box_h),
    .colour(colour), .canvas_w(canvas_w), .canvas_h(canvas_h),
    .out_valid(out_valid), .out_ready(out_ready), .write_ok(write_ok),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .attribute(attribute),
    .walk_done(walk_done)
  );
endmodule
`default_nettype wire

### rtl/elr_extent.sv
// Iterative exact extent search: largest r in 0..255 with (2r-1)^2*d2 <= n2*v.
`default_nettype none
module elr_extent (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  den,   // |A|, 0..253
  input  wire logic [7:0]  num,   // |B|
  input  wire logic [16:0] v,     // clamped to >= 0
  output logic             busy,
  output logic [7:0]       r
);
  // Operands and their squares are registered on start; the product num^2*v is then
  // registered into rhs, and r climbs while (2r+1)^2*d2 <= rhs, one test per cycle.
  logic [15:0] d2;
  logic [15:0] n2;
  logic [16:0] vv;
  logic [32:0] rhs;
  logic [17:0] tsq;     // (2r+1)^2, up to 511^2
  logic [1:0]  phase;
  logic [32:0] lhs;

  assign lhs = 33'(tsq) * 33'(d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 2'd0;
      d2    <= 16'(den) * 16'(den);
      n2    <= 16'(num) * 16'(num);
      vv    <= v;
      r     <= 8'd0;
      tsq   <= 18'd1;
    end else if (busy) begin
      case (phase)
        2'd0: begin
          rhs   <= 33'(n2) * 33'(vv);
          phase <= 2'd1;
        end
        default: begin
          if (r == 8'd255 || lhs > rhs) begin
            busy <= 1'b0;
          end else begin
            // (2r+3)^2 = (2r+1)^2 + 8r + 8
            tsq <= tsq + 18'({r, 3'b000}) + 18'd8;
            r   <= r + 8'd1;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/elr_front.sv
// Front part: accepts restart and advance words, walks the ellipse and queues positions.
`default_nettype none
module elr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              restart,
  input  wire logic [7:0]        box_w,
  input  wire logic [7:0]        box_h,
  input  wire logic              fill,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output elr_pkg::elr_cmd_t      q_cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETTLE = 3'd1;
  localparam logic [2:0] S_EXT   = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0] state;
  logic [1:0] phase;
  logic [8:0] outer;
  logic [8:0] span;
  logic [1:0] step;
  logic [7:0] r;
  logic       post;     // settle after emit decides done
  logic       ext_ok;   // r valid for current outer
  logic [7:0] ext_w;    // box size r was found for
  logic [7:0] ext_h;
  logic       ext_hit;
  logic       first;    // current word is a restart
  logic       start_ext;
  logic       ext_busy;
  logic [7:0] ext_r;

  logic signed [9:0]  a_s, b_s;
  logic [8:0] a_t2, b_t2;   // 2*(A/2)
  logic signed [9:0]  off;
  logic signed [19:0] vsq;
  logic [7:0]  den, num;
  logic [16:0] vclamp;

  // queue: two entries
  elr_pkg::elr_cmd_t qmem [2];
  logic [1:0] qcnt;
  logic       qwr, qrd, wp, rp;
  elr_pkg::elr_cmd_t wcmd;

  // held emitted position, queued once the following settle is known
  elr_pkg::elr_cmd_t q_hold;

  assign a_s = 10'(box_w) - 10'sd2;
  assign b_s = 10'(box_h) - 10'sd2;
  assign a_t2 = (a_s > 0) ? {a_s[8:1], 1'b0} : 9'd0;
  assign b_t2 = (b_s > 0) ? {b_s[8:1], 1'b0} : 9'd0;
  // x = outer - t
  assign off = (phase == elr_pkg::PH_COL) ?
               $signed({1'b0, outer}) - $signed({1'b0, a_t2[8:1]}) :
               $signed({1'b0, outer}) - $signed({1'b0, b_t2[8:1]});
  assign vsq = (phase == elr_pkg::PH_COL) ? a_s * a_s - 20'sd4 * off * off
                                          : b_s * b_s - 20'sd4 * off * off;
  assign vclamp = vsq[19] ? 17'd0 : vsq[16:0];
  assign den = (phase == elr_pkg::PH_COL) ? a_s[7:0] : b_s[7:0];
  assign num = (phase == elr_pkg::PH_COL) ? (b_s[9] ? 8'(-b_s) : b_s[7:0])
                                          : (a_s[9] ? 8'(-a_s) : a_s[7:0]);

  // a held extent is stale once the box size changes
  assign ext_hit = ext_ok && (ext_w == box_w) && (ext_h == box_h);

  elr_extent u_ext (
    .clk(clk), .rst(rst), .start(start_ext), .den(den), .num(num),
    .v(vclamp), .busy(ext_busy), .r(ext_r)
  );

  assign in_ready = (state == S_IDLE) && (qcnt != 2'd2);
  assign q_valid  = (qcnt != 2'd0);
  assign q_cmd    = qmem[rp];
  assign qrd      = q_valid && q_ready;

  always_comb begin
    qwr = 1'b0;
    start_ext = 1'b0;
    wcmd = '0;
    wcmd.col = (phase == elr_pkg::PH_COL);
    wcmd.outer = outer;
    wcmd.step = step;
    wcmd.span = span;
    wcmd.r = r;
    if (state == S_IDLE && in_valid && !restart && phase == elr_pkg::PH_IDLE &&
        qcnt != 2'd2) begin
      qwr = 1'b1;
      wcmd.empty = 1'b1;
    end
    if (state == S_SETTLE && phase == elr_pkg::PH_IDLE && !post && qcnt != 2'd2) begin
      qwr = 1'b1;
      wcmd.empty = 1'b1;
      wcmd.done = first;
    end
    if (state == S_SETTLE && phase != elr_pkg::PH_IDLE && !ext_hit) start_ext = 1'b1;
    if (state == S_POST && qcnt != 2'd2) begin
      qwr = 1'b1;
      wcmd = q_hold;
      wcmd.done = (phase == elr_pkg::PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (qwr) qmem[wp] <= wcmd;
  end

  // settle-and-emit sequencer
  logic col_end, row_end, col_adv;
  assign col_end = (a_s <= 0) || (outer > a_t2);
  assign row_end = (b_s <= 0) || (outer > b_t2);
  assign col_adv = (step == 2'd3) ||
                   (step == 2'd2 && (!fill || span > {r, 1'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= elr_pkg::PH_IDLE;
      qcnt <= 2'd0; wp <= 1'b0; rp <= 1'b0;
      outer <= '0; span <= '0; step <= '0; r <= '0;
      post <= 1'b0; ext_ok <= 1'b0; first <= 1'b0;
    end else begin
      qcnt <= qcnt + 2'(qwr) - 2'(qrd);
      if (qwr) wp <= ~wp;
      if (qrd) rp <= ~rp;
      case (state)
        S_IDLE: begin
          if (in_valid && qcnt != 2'd2) begin
            first <= restart;
            if (restart) begin
              phase <= elr_pkg::PH_COL;
              outer <= '0; step <= '0; span <= '0;
              ext_ok <= 1'b0; post <= 1'b0;
              state <= S_SETTLE;
            end else if (phase != elr_pkg::PH_IDLE) begin
              // advance a running walk
              state <= S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          if (phase == elr_pkg::PH_COL) begin
            if (col_end) begin
              phase <= elr_pkg::PH_ROW; outer <= '0; step <= '0; span <= '0;
              ext_ok <= 1'b0;
            end else if (!ext_hit) begin
              state <= S_WAIT;
            end else if (col_adv) begin
              outer <= outer + 9'd1; step <= '0; span <= '0; ext_ok <= 1'b0;
            end else begin
              state <= post ? S_POST : S_EMIT;
            end
          end else if (phase == elr_pkg::PH_ROW) begin
            if (row_end) begin
              phase <= elr_pkg::PH_IDLE; outer <= '0; step <= '0; span <= '0;
            end else if (step >= 2'd2) begin
              outer <= outer + 9'd1; step <= '0; ext_ok <= 1'b0;
            end else if (!ext_hit) begin
              state <= S_WAIT;
            end else begin
              state <= post ? S_POST : S_EMIT;
            end
          end else begin
            // idle: an empty walk is queued now, the final emit is queued in S_POST
            if (post) begin
              state <= S_POST;
            end else if (qcnt != 2'd2) begin
              state <= S_IDLE;
            end
          end
        end
        S_WAIT: state <= S_EXT;
        S_EXT: begin
          if (!ext_busy) begin
            r <= ext_r; ext_ok <= 1'b1; state <= S_SETTLE;
            ext_w <= box_w; ext_h <= box_h;
          end
        end
        S_EMIT: begin
          // capture the position to emit, then advance and re-settle
          q_hold <= wcmd;
          if (phase == elr_pkg::PH_COL) begin
            if (step == 2'd0) step <= 2'd1;
            else if (step == 2'd1) begin step <= 2'd2; span <= '0; end
            else span <= span + 9'd1;
          end else begin
            step <= step + 2'd1;
          end
          post <= 1'b1;
          state <= S_SETTLE;
        end
        S_POST: begin
          if (qcnt != 2'd2) begin
            post <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/elr_back.sv
// Back part: turns walk positions into clipped pixel writes.
`default_nettype none
module elr_back #(
  parameter int MAX_DIM = elr_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  elr_pkg::elr_cmd_t      q_cmd,
  input  wire logic [8:0]        org_x,
  input  wire logic [8:0]        org_y,
  input  wire logic [7:0]        box_w,
  input  wire logic [7:0]        box_h,
  input  wire logic [3:0]        colour,
  input  wire logic [8:0]        canvas_w,
  input  wire logic [8:0]        canvas_h,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   write_ok,
  output logic [7:0]             pixel_x,
  output logic [7:0]             pixel_y,
  output logic [7:0]             attribute,
  output logic                   walk_done
);
  localparam int LIM = (MAX_DIM < 256) ? MAX_DIM : 256;

  logic signed [11:0] cx, cy, dx, dy, px, py, lx, ly;
  logic signed [11:0] rr, at, bt;
  logic ok;

  assign rr = 12'(q_cmd.r);
  assign at = 12'(box_w - 8'd2) >>> 1;
  assign bt = 12'(box_h - 8'd2) >>> 1;
  assign cx = 12'($signed(org_x)) + 12'(box_w[7:1]);
  assign cy = 12'($signed(org_y)) + 12'(box_h[7:1]);
  assign lx = (canvas_w > 9'(LIM)) ? 12'(LIM) : 12'(canvas_w);
  assign ly = (canvas_h > 9'(LIM)) ? 12'(LIM) : 12'(canvas_h);

  always_comb begin
    if (q_cmd.col) begin
      dx = 12'(q_cmd.outer) - (($signed(12'(box_w)) - 12'sd2) / 12'sd2);
      case (q_cmd.step)
        2'd0: dy = rr;
        2'd1: dy = -rr;
        default: dy = -rr + 12'(q_cmd.span);
      endcase
    end else begin
      dy = 12'(q_cmd.outer) - (($signed(12'(box_h)) - 12'sd2) / 12'sd2);
      dx = (q_cmd.step == 2'd0) ? rr : -rr;
    end
  end

  assign px = cx + dx;
  assign py = cy + dy;
  assign ok = !q_cmd.empty && px >= 0 && px < lx && py >= 0 && py < ly;

  assign q_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
    if (q_ready && q_valid) begin
      write_ok  <= ok;
      pixel_x   <= ok ? px[7:0] : 8'd0;
      pixel_y   <= ok ? py[7:0] : 8'd0;
      attribute <= {colour, colour};
      walk_done <= q_cmd.done;
    end
  end

  logic unused;
  assign unused = ^{at, bt};
endmodule
`default_nettype wire

### rtl/elr_checker.sv
// Port-level checker for the ellipse rasterizer, bound to the top level.
`default_nettype none
module elr_props (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       write_ok,
  input wire logic [7:0] pixel_x,
  input wire logic [7:0] pixel_y,
  input wire logic [7:0] attribute
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x))
    else $error("output word dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_ok |-> pixel_x == 8'd0 && pixel_y == 8'd0)
    else $error("clipped point has coordinates");
  a_attr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> attribute[7:4] == attribute[3:0])
    else $error("attribute nibbles differ");
endmodule

bind ellipse_rasterizer_unit elr_props u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .write_ok(write_ok), .pixel_x(pixel_x), .pixel_y(pixel_y), .attribute(attribute)
);
`default_nettype wire

### tb/sv/elr_checker.sv
// Ellipse rasterizer checker: tracks registers, predicts each pixel word, compares outputs.
`timescale 1ns / 100ps
module elr_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       restart,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       write_ok,
  input  logic [7:0] pixel_x,
  input  logic [7:0] pixel_y,
  input  logic [7:0] attribute,
  input  logic       walk_done,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         mismatches,
  output int         pending,
  output int         words_seen,
  output int         points_written,
  output int         walks_ended
);
  typedef struct packed {
    logic       ok;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] attr;
    logic       done;
  } pixel_word_t;

  pixel_word_t pixel_q[$];

  // shadow registers
  logic [8:0] sh_ox, sh_oy, sh_cw, sh_ch;
  logic [7:0] sh_w, sh_h;
  logic [3:0] sh_colour;
  logic       sh_fill;

  // walk position
  logic [1:0] phase;
  logic [8:0] outer, span;
  logic [1:0] step;
  int         ext;

  // largest r in 0..255 with (2r-1)^2*den^2 <= num^2*v
  function automatic int extent_of(int den, int num, int v);
    longint d, rhs, t;
    int     r;
    d   = longint'(den) * den;
    rhs = (v < 0) ? 0 : longint'(num) * num * v;
    r   = 0;
    while (r < 255) begin
      t = 2 * r + 1;
      if (t * t * d > rhs) break;
      r++;
    end
    return r;
  endfunction

  // advance to the next point to emit, or drop to idle
  task automatic walk_settle();
    int aa, bb, x, y, r;
    bit go;
    go = 1;
    while (go) begin
      aa = int'(sh_w) - 2;
      bb = int'(sh_h) - 2;
      if (phase == elr_pkg::PH_COL) begin
        if (aa <= 0 || int'(outer) > 2 * (aa / 2)) begin
          phase = elr_pkg::PH_ROW; outer = '0; step = '0; span = '0;
        end else begin
          x = int'(outer) - aa / 2;
          r = extent_of(aa, bb, aa * aa - 4 * x * x);
          if (step >= 3 || (step == 2 && (!sh_fill || int'(span) > 2 * r))) begin
            outer = outer + 1'b1; step = '0; span = '0;
          end else begin
            ext = r; go = 0;
          end
        end
      end else if (phase == elr_pkg::PH_ROW) begin
        if (bb <= 0 || int'(outer) > 2 * (bb / 2)) begin
          phase = elr_pkg::PH_IDLE; outer = '0; step = '0; span = '0; go = 0;
        end else if (step >= 2) begin
          outer = outer + 1'b1; step = '0;
        end else begin
          y = int'(outer) - bb / 2;
          ext = extent_of(bb, aa, bb * bb - 4 * y * y);
          go = 0;
        end
      end else begin
        phase = elr_pkg::PH_IDLE; go = 0;
      end
    end
  endtask

  task automatic predict_pixel(input logic rs, output pixel_word_t w);
    int aa, bb, cx, cy, dx, dy, px, py, lim_x, lim_y;
    w = '0;
    w.attr = {sh_colour, sh_colour};
    if (rs) begin
      phase = elr_pkg::PH_COL; outer = '0; step = '0; span = '0;
      walk_settle();
      if (phase == elr_pkg::PH_IDLE) begin
        w.done = 1'b1;
        return;
      end
    end else begin
      walk_settle();
      if (phase == elr_pkg::PH_IDLE) return;
    end
    aa = int'(sh_w) - 2;
    bb = int'(sh_h) - 2;
    cx = int'($signed(sh_ox)) + int'(sh_w) / 2;
    cy = int'($signed(sh_oy)) + int'(sh_h) / 2;
    if (phase == elr_pkg::PH_COL) begin
      dx = int'(outer) - aa / 2;
      if (step == 0) dy = ext;
      else if (step == 1) dy = -ext;
      else dy = -ext + int'(span);
      if (step == 0) step = 2'd1;
      else if (step == 1) begin
        step = 2'd2; span = '0;
      end else span = span + 1'b1;
    end else begin
      dy = int'(outer) - bb / 2;
      dx = (step == 0) ? ext : -ext;
      step = step + 1'b1;
    end
    px = cx + dx;
    py = cy + dy;
    lim_x = (int'(sh_cw) > 256) ? 256 : int'(sh_cw);
    lim_y = (int'(sh_ch) > 256) ? 256 : int'(sh_ch);
    if (px >= 0 && px < lim_x && py >= 0 && py < lim_y) begin
      w.ok = 1'b1;
      w.x  = px[7:0];
      w.y  = py[7:0];
    end
    walk_settle();
    w.done = (phase == elr_pkg::PH_IDLE);
  endtask

  always @(posedge clk) begin
    pixel_word_t w, e;
    if (rst) begin
      sh_ox = '0; sh_oy = '0; sh_w = '0; sh_h = '0;
      sh_colour = '0; sh_fill = 1'b0; sh_cw = 9'd256; sh_ch = 9'd256;
      phase = elr_pkg::PH_IDLE; outer = '0; span = '0; step = '0; ext = 0;
      pixel_q.delete();
      pending = 0;
      mismatches <= 0; words_seen <= 0; points_written <= 0; walks_ended <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          elr_pkg::CFG_ORIGIN_X: sh_ox = cfg_data;
          elr_pkg::CFG_ORIGIN_Y: sh_oy = cfg_data;
          elr_pkg::CFG_BOX_W:    sh_w = cfg_data[7:0];
          elr_pkg::CFG_BOX_H:    sh_h = cfg_data[7:0];
          elr_pkg::CFG_COLOUR:   sh_colour = cfg_data[3:0];
          elr_pkg::CFG_FILL:     sh_fill = cfg_data[0];
          elr_pkg::CFG_CANVAS_W: sh_cw = cfg_data;
          elr_pkg::CFG_CANVAS_H: sh_ch = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_pixel(restart, w);
        pixel_q.push_back(w);
      end
      if (out_valid && out_ready) begin
        words_seen <= words_seen + 1;
        if (write_ok) points_written <= points_written + 1;
        if (walk_done) walks_ended <= walks_ended + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected word ok=%0d x=%0d y=%0d attr=%0d done=%0d",
                   $time, write_ok, pixel_x, pixel_y, attribute, walk_done);
          mismatches <= mismatches + 1;
        end else begin
          e = pixel_q.pop_front();
          if (e.ok !== write_ok || e.x !== pixel_x || e.y !== pixel_y ||
              e.attr !== attribute || e.done !== walk_done) begin
            $display("%0t: mismatch expected ok=%0d x=%0d y=%0d attr=%0d done=%0d",
                     $time, e.ok, e.x, e.y, e.attr, e.done);
            $display("%0t:          actual   ok=%0d x=%0d y=%0d attr=%0d done=%0d",
                     $time, write_ok, pixel_x, pixel_y, attribute, walk_done);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending = pixel_q.size();
    end
  end
endmodule

### tb/sv/tb.sv
// Testbench top: clock, reset, shape setup and walk stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0, restart = 1'b0;
  logic       in_ready;
  logic       out_valid, out_ready = 1'b0;
  logic       write_ok, walk_done;
  logic [7:0] pixel_x, pixel_y, attribute;
  logic       cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  int  mismatches, pending, words_seen, points_written, walks_ended;
  int  items_sent = 0;
  int  shapes_set = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  always #10 clk = ~clk;

  ellipse_rasterizer_unit u_dut (
    .clk, .rst, .in_valid, .in_ready, .restart,
    .out_valid, .out_ready, .write_ok, .pixel_x, .pixel_y, .attribute, .walk_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  elr_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .restart,
    .out_valid, .out_ready, .write_ok, .pixel_x, .pixel_y, .attribute, .walk_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .pending, .words_seen, .points_written, .walks_ended
  );

  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input logic rs);
    if (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last register
  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // hold the sender until all words are back, then load the whole shape
  task automatic set_shape(input int ox, input int oy, input int w, input int h,
                           input int colour, input int fill, input int cw, input int ch);
    drain();
    write_reg(elr_pkg::CFG_ORIGIN_X, 9'(ox));
    write_reg(elr_pkg::CFG_ORIGIN_Y, 9'(oy));
    write_reg(elr_pkg::CFG_BOX_W, 9'(w));
    write_reg(elr_pkg::CFG_BOX_H, 9'(h));
    write_reg(elr_pkg::CFG_COLOUR, 9'(colour));
    write_reg(elr_pkg::CFG_FILL, 9'(fill));
    write_reg(elr_pkg::CFG_CANVAS_W, 9'(cw));
    write_reg(elr_pkg::CFG_CANVAS_H, 9'(ch));
    cfg_valid <= 1'b0;
    shapes_set++;
  endtask

  task automatic walk(input int n, input int restart_odds);
    send_word(1'b1);
    for (int i = 0; i < n; i++) begin
      send_word((restart_odds > 0 && $urandom_range(restart_odds - 1) == 0));
    end
  endtask

  initial begin
    int w, h, bad;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle advance, empty walk from reset shape, idle again
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    // zero half-axes: empty walk
    set_shape(0, 0, 2, 2, 1, 1, 256, 256);
    walk(1, 0);
    // odd tiny box, filled, top colour
    set_shape(10, 10, 3, 3, 15, 1, 256, 256);
    walk(5, 0);
    // fully clipped off the low corner
    set_shape(-256, -256, 6, 5, 0, 1, 256, 256);
    walk(3, 0);
    // high corner, outline only
    set_shape(255, 255, 4, 4, 5, 0, 256, 256);
    walk(3, 0);
    // row pass only, one-column canvas
    set_shape(0, 0, 2, 9, 3, 1, 1, 256);
    walk(3, 0);
    // largest box on a one-row canvas
    set_shape(0, 0, 255, 255, 9, 0, 256, 1);
    walk(2, 0);

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 500 && items_sent < 700);
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(200, 255);
        h = $urandom_range(0, 255);
      end else begin
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 24);
      end
      set_shape(($urandom_range(1)) ? $urandom_range(0, 511) : $urandom_range(0, 220) - 20,
                ($urandom_range(1)) ? $urandom_range(0, 511) : $urandom_range(0, 220) - 20,
                w, h, $urandom_range(0, 15), (w > 100) ? 0 : $urandom_range(1),
                ($urandom_range(2) == 0) ? 256 : $urandom_range(1, 256),
                ($urandom_range(2) == 0) ? 256 : $urandom_range(1, 256));
      walk($urandom_range(5, 120), 30);
    end
    calm = 1'b0;
    drain();
    repeat (300) @(posedge clk);

    $display("Shapes loaded: %0d, input words: %0d, output words: %0d",
             shapes_set, items_sent, words_seen);
    $display("Points written: %0d, walks ended: %0d", points_written, walks_ended);
    bad = mismatches + pending;
    if (pending != 0) $display("%0t: %0d expected words never arrived", $time, pending);
    if (bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
